[design/assert_macros.svh]
// assertion helper macros used by the frame_rate_meter_limiter_unit rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every aclk edge outside reset
`define AST_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// implication checked on every aclk edge outside reset
`define AST_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/frml_pkg.sv]
// package for the frame rate meter: widths, constants and the microcode table
`timescale 1ns / 1ps

package frml_pkg;

    localparam int TS_W      = 32;
    localparam int FT_W      = 16;
    localparam int FPS_W     = 22;
    localparam int DLY_W     = 10;
    localparam int MAXFPS_W  = 10;

    localparam int WINDOW_DEPTH_DEF = 10;

    localparam logic [MAXFPS_W-1:0] MAX_FPS_RST   = 10'd60;
    localparam logic [FPS_W-1:0]    FPS_DEFAULT   = 22'd15360;
    localparam logic [FPS_W-1:0]    FPS_MAX       = 22'h3FFFFF;
    localparam logic [FT_W-1:0]     FT_MAX        = 16'hFFFF;
    localparam int                  FPS_SCALE     = 256000;
    localparam logic [DLY_W-1:0]    MS_PER_S      = 10'd1000;

    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH   = 4'd0;
    localparam step_t STEP_FRAME   = 4'd1;
    localparam step_t STEP_SUB_OLD = 4'd2;
    localparam step_t STEP_ADD_NEW = 4'd3;
    localparam step_t STEP_LD_FPS  = 4'd4;
    localparam step_t STEP_DIV_FPS = 4'd5;
    localparam step_t STEP_ST_FPS  = 4'd6;
    localparam step_t STEP_LD_LIM  = 4'd7;
    localparam step_t STEP_DIV_LIM = 4'd8;
    localparam step_t STEP_EMIT    = 4'd9;

    // datapath operation of one step
    typedef enum logic [3:0] {
        OP_FETCH,
        OP_FRAME,
        OP_SUB_OLD,
        OP_ADD_NEW,
        OP_LD_FPS,
        OP_DIV_STEP,
        OP_ST_FPS,
        OP_LD_LIM,
        OP_EMIT
    } op_t;

    // how the step counter moves
    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_LOOP,
        SQ_WAIT_IN,
        SQ_WAIT_OUT
    } seq_t;

    typedef struct packed {
        op_t   op;
        seq_t  seq;
        step_t target;
    } ucode_t;

    function automatic ucode_t frml_ucode(input step_t step);
        ucode_t w;
        unique case (step)
            STEP_FETCH:   w = '{op: OP_FETCH,    seq: SQ_WAIT_IN,  target: STEP_FETCH};
            STEP_FRAME:   w = '{op: OP_FRAME,    seq: SQ_NEXT,     target: STEP_FETCH};
            STEP_SUB_OLD: w = '{op: OP_SUB_OLD,  seq: SQ_NEXT,     target: STEP_FETCH};
            STEP_ADD_NEW: w = '{op: OP_ADD_NEW,  seq: SQ_NEXT,     target: STEP_FETCH};
            STEP_LD_FPS:  w = '{op: OP_LD_FPS,   seq: SQ_NEXT,     target: STEP_FETCH};
            STEP_DIV_FPS: w = '{op: OP_DIV_STEP, seq: SQ_LOOP,     target: STEP_DIV_FPS};
            STEP_ST_FPS:  w = '{op: OP_ST_FPS,   seq: SQ_NEXT,     target: STEP_FETCH};
            STEP_LD_LIM:  w = '{op: OP_LD_LIM,   seq: SQ_NEXT,     target: STEP_FETCH};
            STEP_DIV_LIM: w = '{op: OP_DIV_STEP, seq: SQ_LOOP,     target: STEP_DIV_LIM};
            STEP_EMIT:    w = '{op: OP_EMIT,     seq: SQ_WAIT_OUT, target: STEP_FETCH};
            default:      w = '{op: OP_FETCH,    seq: SQ_WAIT_IN,  target: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

[design/frml_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module frml_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 10,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/frame_rate_meter_limiter_unit.sv]
// frame_rate_meter_limiter_unit: moving-average frame rate meter with limiter delay.
// Each input transaction is a frame-begin (kind 0) or frame-end (kind 1) event with a
// free-running millisecond timestamp. A begin event only records the frame start.
// An end event yields one result transaction: the frame time since the
// previous end (zero for the first end after reset, saturated to 65535 ms), the average
// rate 256000*count/sum in unsigned Q8 over the last WINDOW_DEPTH frame times (60.0 when
// the sum is zero, saturated to 22 bits) and the delay floor(1000/max_fps) minus the
// time since the last begin, or zero. Once an end event is accepted, no transaction is
// accepted until its result has been loaded into the output register. The rate quotient
// (NUM_W steps, where NUM_W is 22 at WINDOW_DEPTH = 10) and the limiter quotient (10
// steps) share one restoring divider that produces one quotient bit per cycle.
// A finished result waits in the output register while the next transaction is
// accepted; the next end event stalls in its emit step until that result is taken.
// max_fps is written through cfg_wr_en / cfg_wr_data at any idle time and resets to 60.
`timescale 1ns / 1ps

module frame_rate_meter_limiter_unit #(
    parameter int WINDOW_DEPTH = frml_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [frml_pkg::MAXFPS_W-1:0] cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [frml_pkg::TS_W-1:0]     s_timestamp_ms,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [frml_pkg::FPS_W-1:0]    m_fps_q8,
    output logic [frml_pkg::FT_W-1:0]     m_frame_time_ms,
    output logic [frml_pkg::DLY_W-1:0]    m_delay_ms
);

    import frml_pkg::*;

    `include "assert_macros.svh"

    // derived widths
    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = $clog2(WINDOW_DEPTH * 65535 + 1);
    localparam int NUM_W  = $clog2(WINDOW_DEPTH * FPS_SCALE + 1);
    localparam int DEN_W  = (SUM_W > MAXFPS_W) ? SUM_W : MAXFPS_W;
    localparam int ITER_W = $clog2(NUM_W + 1);
    localparam int QX_W   = (NUM_W > FPS_W) ? NUM_W : FPS_W;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);

    // sequencer
    step_t  step_reg, step_next;
    ucode_t uword;

    // event and ring state
    logic [TS_W-1:0]     now_reg, now_next;
    logic [TS_W-1:0]     start_reg, start_next;
    logic [TS_W-1:0]     prev_reg, prev_next;
    logic                seen_reg, seen_next;
    logic [TS_W-1:0]     elapsed_reg, elapsed_next;
    logic [FT_W-1:0]     ft_reg, ft_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [MAXFPS_W-1:0] max_fps_reg, max_fps_next;

    // shared divider
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [DEN_W:0]      rem_shift;
    logic                rem_ge;

    logic [FPS_W-1:0]    fps_reg, fps_next;
    logic [QX_W-1:0]     quo_ext;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [FPS_W-1:0]    m_fps_reg, m_fps_next;
    logic [FT_W-1:0]     m_ft_reg, m_ft_next;
    logic [DLY_W-1:0]    m_dly_reg, m_dly_next;

    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic [TS_W-1:0]     span;
    logic [DLY_W-1:0]    limit;
    logic                ram_we;
    logic [FT_W-1:0]     ram_rd_data;

    // frame time ring
    frml_ram #(
        .DATA_W (FT_W),
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (ft_reg),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    assign uword    = frml_ucode(step_reg);
    assign s_ready  = (uword.seq == SQ_WAIT_IN);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    assign span    = now_reg - prev_reg;
    assign quo_ext = QX_W'(quo_reg);
    assign limit   = (max_fps_reg == '0) ? '0 : quo_reg[DLY_W-1:0];

    always_comb begin
        step_next    = step_reg;
        now_next     = now_reg;
        start_next   = start_reg;
        prev_next    = prev_reg;
        seen_next    = seen_reg;
        elapsed_next = elapsed_reg;
        ft_next      = ft_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        max_fps_next = max_fps_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        den_next     = den_reg;
        iter_next    = iter_reg;
        fps_next     = fps_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_fps_next   = m_fps_reg;
        m_ft_next    = m_ft_reg;
        m_dly_next   = m_dly_reg;
        ram_we       = 1'b0;
        out_load     = 1'b0;

        if (cfg_wr_en) begin
            max_fps_next = cfg_wr_data;
        end

        unique case (uword.op)
            OP_FETCH: begin
                if (in_acc) begin
                    if (s_kind == KIND_END) begin
                        now_next = s_timestamp_ms;
                    end else begin
                        start_next = s_timestamp_ms;
                    end
                end
            end
            OP_FRAME: begin
                // frame time since previous end, saturated; zero on the first end
                if (!seen_reg) begin
                    ft_next = '0;
                end else if (span[TS_W-1:FT_W] != '0) begin
                    ft_next = FT_MAX;
                end else begin
                    ft_next = span[FT_W-1:0];
                end
                prev_next    = now_reg;
                seen_next    = 1'b1;
                elapsed_next = now_reg - start_reg;
            end
            OP_SUB_OLD: begin
                // ring read data for the slot about to be overwritten is valid now
                if (cnt_reg == CNT_FULL) begin
                    sum_next = sum_reg - SUM_W'(ram_rd_data);
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_ADD_NEW: begin
                sum_next = sum_reg + SUM_W'(ft_reg);
                ram_we   = 1'b1;
                idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
            end
            OP_LD_FPS: begin
                quo_next  = NUM_W'(cnt_reg) * NUM_W'(FPS_SCALE);
                den_next  = DEN_W'(sum_reg);
                rem_next  = '0;
                iter_next = ITER_W'(NUM_W);
            end
            OP_DIV_STEP: begin
                rem_next  = rem_ge ? DEN_W'(rem_shift - {1'b0, den_reg}) : DEN_W'(rem_shift);
                quo_next  = {quo_reg[NUM_W-2:0], rem_ge};
                iter_next = iter_reg - 1'b1;
            end
            OP_ST_FPS: begin
                if (sum_reg == '0) begin
                    fps_next = FPS_DEFAULT;
                end else if (quo_ext > QX_W'(FPS_MAX)) begin
                    fps_next = FPS_MAX;
                end else begin
                    fps_next = quo_ext[FPS_W-1:0];
                end
            end
            OP_LD_LIM: begin
                // 1000 sits in the top bits so ten steps leave the quotient in the low bits
                quo_next  = NUM_W'(MS_PER_S) << (NUM_W - DLY_W);
                den_next  = DEN_W'(max_fps_reg);
                rem_next  = '0;
                iter_next = ITER_W'(DLY_W);
            end
            OP_EMIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    m_fps_next   = fps_reg;
                    m_ft_next    = ft_reg;
                    if (TS_W'(limit) > elapsed_reg) begin
                        m_dly_next = limit - elapsed_reg[DLY_W-1:0];
                    end else begin
                        m_dly_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        unique case (uword.seq)
            SQ_NEXT: begin
                step_next = step_reg + 1'b1;
            end
            SQ_LOOP: begin
                step_next = (iter_reg != ITER_W'(1)) ? uword.target : step_reg + 1'b1;
            end
            SQ_WAIT_IN: begin
                if (in_acc && s_kind == KIND_END) begin
                    step_next = step_reg + 1'b1;
                end
            end
            SQ_WAIT_OUT: begin
                if (out_free) begin
                    step_next = uword.target;
                end
            end
            default: begin
                step_next = STEP_FETCH;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_FETCH;
            start_reg   <= '0;
            prev_reg    <= '0;
            seen_reg    <= 1'b0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            max_fps_reg <= MAX_FPS_RST;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            start_reg   <= start_next;
            prev_reg    <= prev_next;
            seen_reg    <= seen_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            max_fps_reg <= max_fps_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        ft_reg      <= ft_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        den_reg     <= den_next;
        iter_reg    <= iter_next;
        fps_reg     <= fps_next;
        m_fps_reg   <= m_fps_next;
        m_ft_reg    <= m_ft_next;
        m_dly_reg   <= m_dly_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_fps_q8        = m_fps_reg;
    assign m_frame_time_ms = m_ft_reg;
    assign m_delay_ms      = m_dly_reg;

    // checks
    `AST_CHK(a_idx_range, idx_reg <= IDX_LAST, "ring index out of range")
    `AST_CHK(a_cnt_range, cnt_reg <= CNT_FULL, "fill count exceeds window depth")
    `AST_IMPL(a_div_iter, uword.op == OP_DIV_STEP, iter_reg != '0, "divider ran out of steps")
    `AST_IMPL(a_load_ret, out_load, ##1 step_reg == STEP_FETCH, "no return to fetch after result")
    `AST_IMPL(a_valid_src, $rose(m_valid_reg), $past(step_reg) == STEP_EMIT, "result outside emit")

endmodule
